[rtl/phcr_pkg.sv]
package phcr_pkg;

    // Configuration register widths and write port
    localparam int CENTER_BITS    = 12;
    localparam int RADIUS_BITS    = 8;
    localparam int CFG_DATA_BITS  = 12;
    localparam int CFG_INDEX_BITS = 2;

    // 3*R and the divider operand 2*(3*R)
    localparam int D3_BITS  = RADIUS_BITS + 2;
    localparam int DIV_BITS = RADIUS_BITS + 3;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_X   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CENTER_Y   = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HEX_RADIUS = CFG_INDEX_BITS'(2);

    // sqrt(3) with 30 fraction bits
    localparam longint unsigned SQRT3_Q30 = 64'd1859775393;

    // Control that travels with each beat through the divider
    typedef struct packed {
        logic valid;
        logic q_neg;
        logic r_neg;
    } phcr_tag_t;

endpackage

[rtl/phcr_div.sv]
module phcr_div #(
    parameter int NW = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [phcr_pkg::DIV_BITS-1:0] divisor,
    input  phcr_pkg::phcr_tag_t           in_tag,
    input  logic [NW-1:0]                 in_num_q,
    input  logic [NW-1:0]                 in_num_r,
    output phcr_pkg::phcr_tag_t           out_tag,
    output logic [NW-1:0]                 out_quo_q,
    output logic [NW-1:0]                 out_quo_r
);
    import phcr_pkg::*;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    // The dividend shifts out at the top while quotient bits shift in at the bottom.
    function automatic logic [DIV_BITS+NW-1:0] div_step(
        input logic [DIV_BITS-1:0] rem,
        input logic [NW-1:0]       num,
        input logic [DIV_BITS-1:0] d
    );
        logic [DIV_BITS:0] trial;
        logic              hit;
        begin
            trial = {rem, num[NW-1]};
            hit   = (trial >= {1'b0, d});
            if (hit)
            begin
                trial = trial - {1'b0, d};
            end
            return {trial[DIV_BITS-1:0], num[NW-2:0], hit};
        end
    endfunction

    phcr_tag_t           tag_reg [NW];
    logic [DIV_BITS-1:0] rq_reg  [NW];
    logic [DIV_BITS-1:0] rr_reg  [NW];
    logic [NW-1:0]       nq_reg  [NW];
    logic [NW-1:0]       nr_reg  [NW];

    for (genvar k = 0; k < NW; k++)
    begin : g_stage
        phcr_tag_t                 tag_src;
        logic [DIV_BITS-1:0]       rq_src;
        logic [DIV_BITS-1:0]       rr_src;
        logic [NW-1:0]             nq_src;
        logic [NW-1:0]             nr_src;
        logic [DIV_BITS+NW-1:0]    step_q_next;
        logic [DIV_BITS+NW-1:0]    step_r_next;

        // Pick the previous stage, or the fresh beat with a clear remainder
        if (k == 0)
        begin : g_first
            assign tag_src = in_tag;
            assign rq_src  = '0;
            assign rr_src  = '0;
            assign nq_src  = in_num_q;
            assign nr_src  = in_num_r;
        end
        else
        begin : g_next
            assign tag_src = tag_reg[k-1];
            assign rq_src  = rq_reg[k-1];
            assign rr_src  = rr_reg[k-1];
            assign nq_src  = nq_reg[k-1];
            assign nr_src  = nr_reg[k-1];
        end

        assign step_q_next = div_step(rq_src, nq_src, divisor);
        assign step_r_next = div_step(rr_src, nr_src, divisor);

        // Advance the valid bit and signs
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k] <= '0;
            end
            else if (en)
            begin
                tag_reg[k] <= tag_src;
            end
        end

        // Advance remainder and dividend/quotient word
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                {rq_reg[k], nq_reg[k]} <= step_q_next;
                {rr_reg[k], nr_reg[k]} <= step_r_next;
            end
        end
    end

    assign out_tag   = tag_reg[NW-1];
    assign out_quo_q = nq_reg[NW-1];
    assign out_quo_r = nr_reg[NW-1];

endmodule

[rtl/pixel_to_hex_cube_round.sv]
// Pointy-top hexagon lookup: each beat on the pixel channel carries one
// screen pixel, and one beat on the hex channel returns the cube coordinates
// (hex_q, hex_r, hex_s) of the hexagon that holds it, in the same order, with
// hex_q + hex_r + hex_s = 0. The pixel is taken relative to center_x/center_y
// and scaled by hex_radius (a radius of 0 acts as 1); fractional coordinates
// carry FRAC_BITS fraction bits and are cube-rounded half away from zero.
// The block takes one pixel every clock while pixel_stall is low. It is built
// around the restoring divider by 2*(3*R), which resolves one quotient bit
// per pipeline stage. A two-entry output buffer lets the pipeline keep
// accepting while a result waits; pixel_stall rises only when that buffer
// is full. Write the configuration registers only while no beats are in
// flight; cfg_ready is always high.
module pixel_to_hex_cube_round #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [phcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [phcr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                pixel_valid,
    output logic                                pixel_stall,
    input  logic [COORD_BITS-1:0]               pixel_x,
    input  logic [COORD_BITS-1:0]               pixel_y,
    output logic                                hex_valid,
    input  logic                                hex_stall,
    output logic signed [COORD_BITS:0]          hex_q,
    output logic signed [COORD_BITS:0]          hex_r,
    output logic signed [COORD_BITS:0]          hex_s
);
    import phcr_pkg::*;

    localparam int XW = COORD_BITS + 1;              // offset pixel, signed
    localparam int KW = FRAC_BITS + 2;               // sqrt3 constant, signed
    localparam int VW = XW + KW;                     // numerators, signed
    localparam int NW = VW + 1;                      // divider dividend
    localparam int SW = NW + 2;                      // fractional coordinates
    localparam int RW = SW - FRAC_BITS + 1;          // rounded coordinates
    localparam int OW = COORD_BITS + 1;              // result fields
    localparam int CM = (COORD_BITS < CENTER_BITS) ? COORD_BITS : CENTER_BITS;
    localparam longint unsigned SQRT3_Q =
        (SQRT3_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    localparam logic signed [KW-1:0] SQRT3_S = KW'(SQRT3_Q);

    // Round to an integer half away from zero; return {value, error}
    function automatic logic [RW+FRAC_BITS-1:0] round_fix(input logic signed [SW-1:0] v);
        logic [SW-1:0]           mag;
        logic [FRAC_BITS-1:0]    frac;
        logic                    up;
        logic [SW-FRAC_BITS-1:0] n;
        logic signed [RW-1:0]    iv;
        logic [FRAC_BITS-1:0]    err;
        begin
            mag  = v[SW-1] ? SW'(-v) : SW'(v);
            frac = mag[FRAC_BITS-1:0];
            up   = frac[FRAC_BITS-1];
            n    = mag[SW-1:FRAC_BITS] + (SW-FRAC_BITS)'(up);
            iv   = v[SW-1] ? -$signed({1'b0, n}) : $signed({1'b0, n});
            err  = up ? (~frac + FRAC_BITS'(1)) : frac;
            return {iv, err};
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CENTER_BITS-1:0] center_x_reg;
    logic [CENTER_BITS-1:0] center_y_reg;
    logic [RADIUS_BITS-1:0] hex_radius_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            hex_radius_reg <= RADIUS_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_CENTER_X:   center_x_reg   <= cfg_data[CENTER_BITS-1:0];
                CFG_CENTER_Y:   center_y_reg   <= cfg_data[CENTER_BITS-1:0];
                CFG_HEX_RADIUS: hex_radius_reg <= cfg_data[RADIUS_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Form 3*R and 2*(3*R); a zero radius acts as one
    logic [RADIUS_BITS-1:0] rad_eff;
    logic [D3_BITS-1:0]     div_d;
    logic [DIV_BITS-1:0]    divisor;

    assign rad_eff = (hex_radius_reg == '0) ? RADIUS_BITS'(1) : hex_radius_reg;
    assign div_d   = D3_BITS'(rad_eff) + D3_BITS'({rad_eff, 1'b0});
    assign divisor = {div_d, 1'b0};

    // ------------------------------------------------------------------
    // Pipeline control: the whole pipeline advances while the skid is empty
    // ------------------------------------------------------------------
    logic skid_valid_reg;
    logic en;

    assign en          = !skid_valid_reg;
    assign pixel_stall = skid_valid_reg;

    // Stage 1: offset by the grid center
    logic [XW-1:0]        cx_ext;
    logic [XW-1:0]        cy_ext;
    logic signed [XW-1:0] s1_x_next;
    logic signed [XW-1:0] s1_y_next;
    logic                 s1_valid_reg;
    logic signed [XW-1:0] s1_x_reg;
    logic signed [XW-1:0] s1_y_reg;

    assign cx_ext    = XW'(center_x_reg[CM-1:0]);
    assign cy_ext    = XW'(center_y_reg[CM-1:0]);
    assign s1_x_next = $signed({1'b0, pixel_x}) - $signed(cx_ext);
    assign s1_y_next = $signed({1'b0, pixel_y}) - $signed(cy_ext);

    // Stage 2: sqrt3*x and y scaled to fixed point
    logic signed [VW-1:0] s2_prod_next;
    logic signed [VW-1:0] s2_ysc_next;
    logic                 s2_valid_reg;
    logic signed [VW-1:0] s2_prod_reg;
    logic signed [VW-1:0] s2_ysc_reg;

    assign s2_prod_next = s1_x_reg * SQRT3_S;
    assign s2_ysc_next  = VW'(s1_y_reg) <<< FRAC_BITS;

    // Stage 3: numerators of q and r
    logic signed [VW-1:0] s3_qn_next;
    logic signed [VW-1:0] s3_rn_next;
    logic                 s3_valid_reg;
    logic signed [VW-1:0] s3_qn_reg;
    logic signed [VW-1:0] s3_rn_reg;

    assign s3_qn_next = s2_prod_reg - s2_ysc_reg;
    assign s3_rn_next = s2_ysc_reg <<< 1;

    // Stage 4: magnitude doubled plus 3*R, for nearest-integer division
    logic [VW-1:0] mq;
    logic [VW-1:0] mr;
    logic [NW-1:0] s4_nq_next;
    logic [NW-1:0] s4_nr_next;
    phcr_tag_t     s4_tag_next;
    phcr_tag_t     s4_tag_reg;
    logic [NW-1:0] s4_nq_reg;
    logic [NW-1:0] s4_nr_reg;

    assign mq          = s3_qn_reg[VW-1] ? VW'(-s3_qn_reg) : VW'(s3_qn_reg);
    assign mr          = s3_rn_reg[VW-1] ? VW'(-s3_rn_reg) : VW'(s3_rn_reg);
    assign s4_nq_next  = {mq, 1'b0} + NW'(div_d);
    assign s4_nr_next  = {mr, 1'b0} + NW'(div_d);
    assign s4_tag_next = '{valid: s3_valid_reg, q_neg: s3_qn_reg[VW-1],
                           r_neg: s3_rn_reg[VW-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_tag_reg   <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= pixel_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_tag_reg   <= s4_tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= s1_x_next;
            s1_y_reg    <= s1_y_next;
            s2_prod_reg <= s2_prod_next;
            s2_ysc_reg  <= s2_ysc_next;
            s3_qn_reg   <= s3_qn_next;
            s3_rn_reg   <= s3_rn_next;
            s4_nq_reg   <= s4_nq_next;
            s4_nr_reg   <= s4_nr_next;
        end
    end

    // ------------------------------------------------------------------
    // Divide both numerators by 2*(3*R), one quotient bit per stage
    // ------------------------------------------------------------------
    phcr_tag_t     div_tag;
    logic [NW-1:0] div_quo_q;
    logic [NW-1:0] div_quo_r;

    phcr_div #(
        .NW (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .divisor   (divisor),
        .in_tag    (s4_tag_reg),
        .in_num_q  (s4_nq_reg),
        .in_num_r  (s4_nr_reg),
        .out_tag   (div_tag),
        .out_quo_q (div_quo_q),
        .out_quo_r (div_quo_r)
    );

    // Stage 5: signed fractional q, r and s
    logic signed [SW-1:0] s5_qf_next;
    logic signed [SW-1:0] s5_rf_next;
    logic signed [SW-1:0] s5_sf_next;
    logic                 s5_valid_reg;
    logic signed [SW-1:0] s5_qf_reg;
    logic signed [SW-1:0] s5_rf_reg;
    logic signed [SW-1:0] s5_sf_reg;

    assign s5_qf_next = div_tag.q_neg ? -$signed(SW'(div_quo_q)) : $signed(SW'(div_quo_q));
    assign s5_rf_next = div_tag.r_neg ? -$signed(SW'(div_quo_r)) : $signed(SW'(div_quo_r));
    assign s5_sf_next = -s5_qf_next - s5_rf_next;

    // Stage 6: round each coordinate and keep its rounding error
    logic signed [RW-1:0]  s6_q_next;
    logic signed [RW-1:0]  s6_r_next;
    logic signed [RW-1:0]  s6_s_next;
    logic [FRAC_BITS-1:0]  s6_eq_next;
    logic [FRAC_BITS-1:0]  s6_er_next;
    logic [FRAC_BITS-1:0]  s6_es_next;
    logic                  s6_valid_reg;
    logic signed [RW-1:0]  s6_q_reg;
    logic signed [RW-1:0]  s6_r_reg;
    logic signed [RW-1:0]  s6_s_reg;
    logic [FRAC_BITS-1:0]  s6_eq_reg;
    logic [FRAC_BITS-1:0]  s6_er_reg;
    logic [FRAC_BITS-1:0]  s6_es_reg;

    assign {s6_q_next, s6_eq_next} = round_fix(s5_qf_reg);
    assign {s6_r_next, s6_er_next} = round_fix(s5_rf_reg);
    assign {s6_s_next, s6_es_next} = round_fix(s5_sf_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg <= div_tag.valid;
            s6_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_qf_reg <= s5_qf_next;
            s5_rf_reg <= s5_rf_next;
            s5_sf_reg <= s5_sf_next;
            s6_q_reg  <= s6_q_next;
            s6_r_reg  <= s6_r_next;
            s6_s_reg  <= s6_s_next;
            s6_eq_reg <= s6_eq_next;
            s6_er_reg <= s6_er_next;
            s6_es_reg <= s6_es_next;
        end
    end

    // Recompute the coordinate with the largest error; a q-r tie goes to r, any tie with s goes to s
    logic signed [RW-1:0] q_fix;
    logic signed [RW-1:0] r_fix;
    logic signed [RW-1:0] s_fix;

    always_comb
    begin
        q_fix = s6_q_reg;
        r_fix = s6_r_reg;
        s_fix = s6_s_reg;
        if (s6_eq_reg > s6_er_reg && s6_eq_reg > s6_es_reg)
        begin
            q_fix = -s6_r_reg - s6_s_reg;
        end
        else if (s6_er_reg > s6_es_reg)
        begin
            r_fix = -s6_q_reg - s6_s_reg;
        end
        else
        begin
            s_fix = -s6_q_reg - s6_r_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one skid entry
    // ------------------------------------------------------------------
    logic          hex_valid_reg;
    logic [OW-1:0] hex_q_reg;
    logic [OW-1:0] hex_r_reg;
    logic [OW-1:0] hex_s_reg;
    logic [OW-1:0] skid_q_reg;
    logic [OW-1:0] skid_r_reg;
    logic [OW-1:0] skid_s_reg;
    logic          hex_valid_next;
    logic          skid_valid_next;
    logic [OW-1:0] hex_q_next;
    logic [OW-1:0] hex_r_next;
    logic [OW-1:0] hex_s_next;
    logic [OW-1:0] skid_q_next;
    logic [OW-1:0] skid_r_next;
    logic [OW-1:0] skid_s_next;
    logic          take;
    logic          out_free;
    logic          push;

    assign take     = hex_valid_reg && !hex_stall;
    assign out_free = !hex_valid_reg || take;
    assign push     = en && s6_valid_reg;

    always_comb
    begin
        hex_valid_next  = hex_valid_reg;
        skid_valid_next = skid_valid_reg;
        hex_q_next      = hex_q_reg;
        hex_r_next      = hex_r_reg;
        hex_s_next      = hex_s_reg;
        skid_q_next     = skid_q_reg;
        skid_r_next     = skid_r_reg;
        skid_s_next     = skid_s_reg;
        if (push)
        begin
            if (out_free)
            begin
                // Load the new beat straight into the output register
                hex_valid_next = 1'b1;
                hex_q_next     = q_fix[OW-1:0];
                hex_r_next     = r_fix[OW-1:0];
                hex_s_next     = s_fix[OW-1:0];
            end
            else
            begin
                // Park the beat while the output waits
                skid_valid_next = 1'b1;
                skid_q_next     = q_fix[OW-1:0];
                skid_r_next     = r_fix[OW-1:0];
                skid_s_next     = s_fix[OW-1:0];
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                // Refill the output from the skid entry
                skid_valid_next = 1'b0;
                hex_q_next      = skid_q_reg;
                hex_r_next      = skid_r_reg;
                hex_s_next      = skid_s_reg;
            end
            else
            begin
                hex_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hex_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            hex_valid_reg  <= hex_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hex_q_reg  <= hex_q_next;
        hex_r_reg  <= hex_r_next;
        hex_s_reg  <= hex_s_next;
        skid_q_reg <= skid_q_next;
        skid_r_reg <= skid_r_next;
        skid_s_reg <= skid_s_next;
    end

    assign hex_valid = hex_valid_reg;
    assign hex_q     = hex_q_reg;
    assign hex_r     = hex_r_reg;
    assign hex_s     = hex_s_reg;

endmodule

[rtl/phcr_checker.sv]
module phcr_checker #(
    parameter int COORD_BITS = 12
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pixel_valid,
    input logic                  pixel_stall,
    input logic                  hex_valid,
    input logic                  hex_stall,
    input logic [COORD_BITS:0]   hex_q,
    input logic [COORD_BITS:0]   hex_r,
    input logic [COORD_BITS:0]   hex_s
);
    localparam int OW = COORD_BITS + 1;

    logic [OW-1:0] cube_sum;

    assign cube_sum = hex_q + hex_r + hex_s;

    // Hold a stalled result beat
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        hex_valid && hex_stall |=> hex_valid)
        else $error("hex_valid dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        hex_valid && hex_stall |=> $stable({hex_q, hex_r, hex_s}))
        else $error("hex payload changed while stalled");

    // Cube coordinates always sum to zero
    a_cube_sum: assert property (@(posedge clk) disable iff (!rst_n)
        hex_valid |-> cube_sum == '0)
        else $error("hex_q + hex_r + hex_s is not zero");

    // Stall the pixel side only after the result side held a stalled beat
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> $past(hex_valid && hex_stall))
        else $error("pixel_stall without a stalled result beat");

    // Hold off a pixel beat only while a result beat is pending
    a_pixel_known: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |-> $past(hex_valid))
        else $error("pixel beat stalled with no result pending");

endmodule

bind pixel_to_hex_cube_round phcr_checker #(.COORD_BITS(COORD_BITS)) u_phcr_checker (.*);

[test/tb_pixel_to_hex_cube_round.sv]
module tb_pixel_to_hex_cube_round;

    import phcr_pkg::*;

    localparam int FRAC_BITS       = 16;
    localparam int COORD_BITS      = 12;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int HOLD_CYCLES     = 150;
    localparam int TAIL_CYCLES     = 45;
    localparam int WATCHDOG_LIMIT  = 2000;

    // Index with no register behind it; writes to it must be ignored
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = CFG_INDEX_BITS'(3);

    // sqrt(3) rounded half up to FRAC_BITS fraction bits
    localparam longint SQRT3_FIX =
        longint'((SQRT3_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));

    typedef struct packed {
        logic signed [COORD_BITS:0] q;
        logic signed [COORD_BITS:0] r;
        logic signed [COORD_BITS:0] s;
    } hex_coord_t;

    typedef struct packed {
        logic [11:0]                cx;
        logic [11:0]                cy;
        logic [11:0]                rdata;
        logic [11:0]                px;
        logic [11:0]                py;
        logic                       known;
        logic signed [COORD_BITS:0] q;
        logic signed [COORD_BITS:0] r;
        logic signed [COORD_BITS:0] s;
    } dir_row_t;

    // Directed pixels: grid setting, pixel, and the result where it is obvious
    localparam int NUM_DIR = 22;
    localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
        // after reset: origin at 0,0, radius 1
        '{12'd0,    12'd0,    12'd1,    12'd0,    12'd0,    1'b1, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'd1,    12'd1,    12'd0,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'd1,    12'd0,    12'd1,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'd1,    12'd0,    12'd2,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'd1,    12'd1,    12'd1,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'd1,    12'd2,    12'd3,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'd1,    12'd4095, 12'd0,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'd1,    12'd0,    12'd4095, 1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'd1,    12'd4095, 12'd4095, 1'b0, 13'sd0, 13'sd0, 13'sd0},
        // mid-screen origin, smallest hexagons, ties around the center
        '{12'd2048, 12'd2048, 12'd1,    12'd2048, 12'd2048, 1'b1, 13'sd0, 13'sd0, 13'sd0},
        '{12'd2048, 12'd2048, 12'd1,    12'd2047, 12'd2049, 1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd2048, 12'd2048, 12'd1,    12'd2049, 12'd2047, 1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd2048, 12'd2048, 12'd1,    12'd2050, 12'd2048, 1'b0, 13'sd0, 13'sd0, 13'sd0},
        // far corner origin, largest hexagons
        '{12'd4095, 12'd4095, 12'd255,  12'd4095, 12'd4095, 1'b1, 13'sd0, 13'sd0, 13'sd0},
        '{12'd4095, 12'd4095, 12'd255,  12'd0,    12'd0,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd4095, 12'd4095, 12'd255,  12'd4095, 12'd0,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd4095, 12'd4095, 12'd255,  12'd0,    12'd4095, 1'b0, 13'sd0, 13'sd0, 13'sd0},
        // zero radius acts as one
        '{12'd4095, 12'd4095, 12'd0,    12'd4094, 12'd4094, 1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd4095, 12'd4095, 12'd0,    12'd0,    12'd0,    1'b0, 13'sd0, 13'sd0, 13'sd0},
        // upper data bits of the radius write are dropped
        '{12'd0,    12'd0,    12'hF7F,  12'd4095, 12'd4095, 1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd0,    12'hF7F,  12'd127,  12'd63,   1'b0, 13'sd0, 13'sd0, 13'sd0},
        '{12'd0,    12'd4095, 12'hFFF,  12'd0,    12'd4095, 1'b1, 13'sd0, 13'sd0, 13'sd0}
    };

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_valid   = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data    = '0;
    logic                       pixel_valid = 1'b0;
    logic                       pixel_stall;
    logic [COORD_BITS-1:0]      pixel_x     = '0;
    logic [COORD_BITS-1:0]      pixel_y     = '0;
    logic                       hex_valid;
    logic                       hex_stall   = 1'b0;
    logic signed [COORD_BITS:0] hex_q;
    logic signed [COORD_BITS:0] hex_r;
    logic signed [COORD_BITS:0] hex_s;

    // Grid setting as last written to the block
    logic [11:0] cur_cx  = 12'd0;
    logic [11:0] cur_cy  = 12'd0;
    logic [7:0]  cur_rad = 8'd1;

    hex_coord_t pending_hex [$];
    int         mismatch_count = 0;
    bit         steady         = 1'b0;
    bit         hold_req       = 1'b0;

    pixel_to_hex_cube_round u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .hex_valid   (hex_valid),
        .hex_stall   (hex_stall),
        .hex_q       (hex_q),
        .hex_r       (hex_r),
        .hex_s       (hex_s)
    );

    always #6 clk = ~clk;

    // Divide and round to nearest, ties away from zero; den > 0
    function automatic longint div_nearest(input longint num, input longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (2 * mag + den) / (2 * den);
        return (num < 0) ? -quo : quo;
    endfunction

    // Round a fixed-point value to an integer, half away from zero
    function automatic longint round_cube(input longint v, output longint err);
        longint mag;
        longint n;
        mag = (v < 0) ? -v : v;
        n   = (mag + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        err = (n <<< FRAC_BITS) - mag;
        if (err < 0)
            err = -err;
        return (v < 0) ? -n : n;
    endfunction

    // Cube coordinates of the pointy-top hexagon holding a pixel
    function automatic hex_coord_t locate_hex(input logic [11:0] px, input logic [11:0] py);
        longint     dx, dy, div3r, y_fix, q_fix, r_fix, s_fix;
        longint     q, r, s, q_err, r_err, s_err;
        hex_coord_t h;
        dx    = longint'(px) - longint'(cur_cx);
        dy    = longint'(py) - longint'(cur_cy);
        div3r = 3 * ((cur_rad == 8'd0) ? 64'sd1 : longint'(cur_rad));
        y_fix = dy * (64'sd1 <<< FRAC_BITS);
        q_fix = div_nearest(SQRT3_FIX * dx - y_fix, div3r);
        r_fix = div_nearest(2 * y_fix, div3r);
        s_fix = -q_fix - r_fix;
        q = round_cube(q_fix, q_err);
        r = round_cube(r_fix, r_err);
        s = round_cube(s_fix, s_err);
        // rebuild the worst-rounded coordinate; a q-r tie goes to r, a tie with s goes to s
        if (q_err > r_err && q_err > s_err)
            q = -r - s;
        else if (r_err > s_err)
            r = -q - s;
        else
            s = -q - r;
        h.q = 13'(q);
        h.r = 13'(r);
        h.s = 13'(s);
        return h;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
            return $urandom_range(1, 3);
        else if (pick < 18)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_coord(input string label, input logic signed [COORD_BITS:0] want,
                               input logic signed [COORD_BITS:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
        end
    endtask

    // Offer one pixel beat and log its expected hexagon once accepted
    task automatic send_pixel(input logic [11:0] px, input logic [11:0] py,
                              input logic typed_in, input hex_coord_t typed);
        int         gap;
        hex_coord_t want_hex;
        gap = steady ? 0 : (($urandom_range(0, 9) < 4) ? 0 : idle_len());
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_x     <= px;
        pixel_y     <= py;
        do
            @(posedge clk);
        while (pixel_stall);
        want_hex    = typed_in ? typed : locate_hex(px, py);
        pending_hex = {pending_hex, want_hex};
    endtask

    // Drop valid and hold until every expected hexagon has come back
    task automatic wait_drained();
        pixel_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_hex.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    // Write the spare index, then both center registers and the radius
    task automatic load_config(input logic [11:0] cx, input logic [11:0] cy,
                               input logic [11:0] rdata);
        logic [CFG_INDEX_BITS-1:0] idx;
        logic [11:0]               val;
        cfg_valid <= 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            case (k)
                0:       begin idx = CFG_SPARE;      val = 12'($urandom); end
                1:       begin idx = CFG_CENTER_X;   val = cx;            end
                2:       begin idx = CFG_CENTER_Y;   val = cy;            end
                default: begin idx = CFG_HEX_RADIUS; val = rdata;         end
            endcase
            cfg_index <= idx;
            cfg_data  <= val;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx)
                CFG_CENTER_X:   cur_cx  = val;
                CFG_CENTER_Y:   cur_cy  = val;
                CFG_HEX_RADIUS: cur_rad = val[7:0];
                default:        ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Check each hex beat against the oldest expected hexagon
    always @(posedge clk)
    begin : check_beat
        hex_coord_t want;
        if (rst_n && hex_valid && !hex_stall)
        begin
            if (pending_hex.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: expected no hex beat, got q=%0d r=%0d s=%0d",
                         $time, hex_q, hex_r, hex_s);
            end
            else
            begin
                want = pending_hex.pop_front();
                check_coord("hex_q", want.q, hex_q);
                check_coord("hex_r", want.r, hex_r);
                check_coord("hex_s", want.s, hex_s);
            end
        end
    end

    // Drive hex_stall: random runs, a long hold on request, none when steady
    initial
    begin : stall_gen
        wait (rst_n);
        forever
        begin
            if (hold_req)
            begin
                hex_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (steady)
            begin
                hex_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                hex_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
                hex_stall <= 1'b1;
                repeat (idle_len()) @(posedge clk);
            end
        end
    end

    // End the run when no beat moves on any channel for too long
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && !pixel_stall) || (hex_valid && !hex_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_pixel_to_hex_cube_round failed");
        $finish;
    end

    initial
    begin : stimulus
        dir_row_t    row;
        hex_coord_t  typed;
        logic [11:0] px, py, cx, cy, rdata;
        int          span, mode;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed rows, reloading the grid only when it changes
        for (int i = 0; i < NUM_DIR; i++)
        begin
            row = DIR_ROWS[i];
            if (row.cx != cur_cx || row.cy != cur_cy || row.rdata[7:0] != cur_rad)
            begin
                wait_drained();
                load_config(row.cx, row.cy, row.rdata);
            end
            typed.q = row.q;
            typed.r = row.r;
            typed.s = row.s;
            send_pixel(row.px, row.py, row.known, typed);
        end

        // Random pixels under a series of grid settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin cx = 12'd0;    cy = 12'd0;    rdata = 12'd1;   end
                1:       begin cx = 12'd4095; cy = 12'd4095; rdata = 12'd255; end
                2:       begin cx = 12'd2048; cy = 12'd2048; rdata = 12'hF00; end
                3:       begin cx = 12'($urandom); cy = 12'($urandom); rdata = 12'($urandom); end
                4:       begin cx = 12'd0;    cy = 12'd4095; rdata = 12'h0FF; end
                5:       begin cx = 12'd4095; cy = 12'd0;    rdata = 12'h001; end
                default: begin
                    cx    = 12'($urandom);
                    cy    = 12'($urandom);
                    rdata = 12'($urandom_range(1, 8));
                end
            endcase
            wait_drained();
            load_config(cx, cy, rdata);
            steady = (p == 1);
            if (p == 2)
                hold_req = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // pause the sender once until the pipe is empty
                if (p == 4 && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                mode = $urandom_range(0, 9);
                span = 3 * ((cur_rad == 8'd0) ? 1 : int'(cur_rad)) + 2;
                if (mode < 4)
                begin
                    px = 12'($urandom);
                    py = 12'($urandom);
                end
                else if (mode < 7)
                begin
                    px = 12'(int'(cur_cx) + $urandom_range(0, 2 * span) - span);
                    py = 12'(int'(cur_cy) + $urandom_range(0, 2 * span) - span);
                end
                else if (mode == 7)
                begin
                    px = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                    py = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                end
                else
                begin
                    px = 12'(int'(cur_cx) + $urandom_range(0, 4) - 2);
                    py = 12'(int'(cur_cy) + $urandom_range(0, 4) - 2);
                end
                send_pixel(px, py, 1'b0, '0);
            end
        end

        wait_drained();
        steady = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_pixel_to_hex_cube_round passed");
        else
            $display("tb_pixel_to_hex_cube_round failed");
        $finish;
    end

endmodule
